// File: design/chs_pkg.sv
package chs_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NEGATIVE  = 3'd5
  } status_e;

  localparam int unsigned ValueW = 32;

endpackage

// File: design/chained_hash_set_unit.sv
// Flow per operation: op code 3 or a negative value goes straight to the result;
//   insert scans the pool from node 0 for the lowest free node;
//   delete/search walk the bucket's chain node by node until a match or its end.
// Throughput: one operation at a time; the next beat is taken only after the
//   result beat has been accepted. Bucket index by reciprocal multiply (S_MUL, S_REM).
// Reset: all buckets empty and all nodes free (flip-flops); node storage not cleared.
module chained_hash_set_unit #(
  parameter int unsigned BUCKETS    = 10,
  parameter int unsigned POOL_NODES = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           op_i,
  input  logic signed [chs_pkg::ValueW-1:0]    value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [2:0]                           status_o
);

  localparam int unsigned NW = $clog2(POOL_NODES + 1);
  localparam int unsigned IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [NW-1:0] Nil = NW'(POOL_NODES);
  localparam int unsigned VW = chs_pkg::ValueW;
  localparam int unsigned SH = VW - 1 + BW;
  localparam int unsigned PW = 2 * VW - 1;
  localparam longint unsigned RecipFull =
    ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [VW-1:0] Recip = VW'(RecipFull);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_REM, S_DISPATCH, S_SCAN, S_READ, S_CHECK, S_DONE
  } state_e;

  state_e              state_q;
  chs_pkg::op_e        op_q;
  logic [VW-1:0]       val_q;
  logic [PW-1:0]       prod_q;
  logic [BW-1:0]       rem_q;
  logic [NW-1:0]       cur_q;
  logic [NW-1:0]       prev_q;
  logic [NW:0]         steps_q;
  logic [2:0]          status_q;
  logic                out_valid_q;

  logic [NW-1:0]       head_q  [BUCKETS];
  logic [BUCKETS-1:0]  head_vld_q;
  logic [POOL_NODES-1:0] free_q;

  logic [VW-1:0]       node_value_mem [POOL_NODES];
  logic [NW-1:0]       node_link_mem  [POOL_NODES];
  logic [VW-1:0]       rd_value_q;
  logic [NW-1:0]       rd_link_q;

  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [VW-1:0]       mem_wvalue;
  logic [NW-1:0]       mem_wlink;
  logic                lnk_we;
  logic [IW-1:0]       lnk_waddr;
  logic [NW-1:0]       lnk_wdata;

  logic [BW-1:0]       bkt;
  logic [NW-1:0]       head_rd;
  logic [VW-1:0]       quo;
  logic [VW-1:0]       rem_full;

  assign bkt      = rem_q;
  assign head_rd  = head_vld_q[bkt] ? head_q[bkt] : Nil;
  assign quo      = VW'(prod_q >> SH);
  assign rem_full = val_q - quo * VW'(BUCKETS);

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_value_mem[mem_waddr] <= mem_wvalue;
      node_link_mem[mem_waddr]  <= mem_wlink;
    end else if (lnk_we) begin
      node_link_mem[lnk_waddr] <= lnk_wdata;
    end
    rd_value_q <= node_value_mem[cur_q[IW-1:0]];
    rd_link_q  <= node_link_mem[cur_q[IW-1:0]];
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = cur_q[IW-1:0];
    mem_wvalue = val_q;
    mem_wlink  = head_rd;
    lnk_we     = 1'b0;
    lnk_waddr  = prev_q[IW-1:0];
    lnk_wdata  = rd_link_q;
    if (state_q == S_SCAN && free_q[cur_q[IW-1:0]]) begin
      mem_we = 1'b1;
    end
    if (state_q == S_CHECK && op_q == chs_pkg::OP_DELETE && rd_value_q == val_q &&
        prev_q != Nil) begin
      lnk_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      head_vld_q  <= '0;
      free_q      <= '1;
      status_q    <= chs_pkg::ST_NOT_FOUND;
      op_q        <= chs_pkg::OP_NONE;
      cur_q       <= Nil;
      prev_q      <= Nil;
      steps_q     <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            op_q  <= chs_pkg::op_e'(op_i);
            val_q <= value_i;
            if (op_i == chs_pkg::OP_NONE) begin
              status_q <= chs_pkg::ST_NOT_FOUND;
              state_q  <= S_DONE;
            end else if (value_i[VW-1]) begin
              status_q <= chs_pkg::ST_NEGATIVE;
              state_q  <= S_DONE;
            end else begin
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_q  <= PW'(val_q[VW-2:0]) * PW'(Recip);
          state_q <= S_REM;
        end
        S_REM: begin
          rem_q   <= rem_full[BW-1:0];
          state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          prev_q  <= Nil;
          steps_q <= '0;
          if (op_q == chs_pkg::OP_INSERT) begin
            cur_q   <= '0;
            state_q <= S_SCAN;
          end else begin
            cur_q   <= head_rd;
            state_q <= S_READ;
          end
        end
        S_SCAN: begin
          if (free_q[cur_q[IW-1:0]]) begin
            free_q[cur_q[IW-1:0]] <= 1'b0;
            head_q[bkt]           <= cur_q;
            head_vld_q[bkt]       <= 1'b1;
            status_q              <= chs_pkg::ST_INSERTED;
            state_q               <= S_DONE;
          end else if (cur_q == NW'(POOL_NODES - 1)) begin
            status_q <= chs_pkg::ST_FULL;
            state_q  <= S_DONE;
          end else begin
            cur_q <= cur_q + NW'(1);
          end
        end
        S_READ: begin
          if (cur_q >= Nil || steps_q == (NW+1)'(POOL_NODES)) begin
            status_q <= chs_pkg::ST_NOT_FOUND;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rd_value_q == val_q) begin
            if (op_q == chs_pkg::OP_DELETE) begin
              if (prev_q == Nil) begin
                head_q[bkt]     <= rd_link_q;
                head_vld_q[bkt] <= 1'b1;
              end
              free_q[cur_q[IW-1:0]] <= 1'b1;
              status_q <= chs_pkg::ST_DELETED;
            end else begin
              status_q <= chs_pkg::ST_FOUND;
            end
            state_q <= S_DONE;
          end else begin
            prev_q  <= cur_q;
            cur_q   <= rd_link_q;
            steps_q <= steps_q + (NW+1)'(1);
            state_q <= S_READ;
          end
        end
        S_DONE: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("ready while result pending");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> out_valid_o)
    else $error("result not raised after done");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= 3'(chs_pkg::ST_NEGATIVE))
    else $error("status out of range");

endmodule

// File: sim/tb_chained_hash_set_unit.sv
module tb_chained_hash_set_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBKT = 10;
  localparam int unsigned NNODE = 64;
  localparam int unsigned NIL = NNODE;
  localparam int unsigned NDIR = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] op_i = chs_pkg::OP_NONE;
  logic signed [chs_pkg::ValueW-1:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] status_o;

  chained_hash_set_unit #(.BUCKETS(NBKT), .POOL_NODES(NNODE)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .op_i(op_i), .value_i(value_i), .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i), .status_o(status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  typedef struct {
    chs_pkg::op_e op;
    logic [31:0] value;
    logic chk;
    chs_pkg::status_e st;
  } vec_t;

  int unsigned bkt_head[NBKT];
  logic [31:0] nd_val[NNODE];
  int unsigned nd_next[NNODE];
  bit nd_free[NNODE];
  chs_pkg::status_e status_q[$];
  logic [31:0] live_vals[$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_cycles = 0;

  function automatic bit find_node(input int unsigned b, input logic [31:0] v,
                                   output int unsigned hit, output int unsigned prv);
    int unsigned cur;
    int unsigned prev_n;
    cur = bkt_head[b];
    prev_n = NIL;
    hit = NIL;
    prv = NIL;
    for (int s = 0; s < NNODE; s++) begin
      if (cur >= NNODE) return 1'b0;
      if (nd_val[cur] == v) begin
        hit = cur;
        prv = prev_n;
        return 1'b1;
      end
      prev_n = cur;
      cur = nd_next[cur];
    end
    return 1'b0;
  endfunction

  function automatic chs_pkg::status_e hash_set_apply(input logic [1:0] op,
                                                      input logic [31:0] v);
    int unsigned b;
    int unsigned n;
    int unsigned hit;
    int unsigned prv;
    if (op == chs_pkg::OP_NONE) return chs_pkg::ST_NOT_FOUND;
    if (v[31]) return chs_pkg::ST_NEGATIVE;
    b = v % NBKT;
    case (op)
      chs_pkg::OP_INSERT: begin
        n = NIL;
        for (int i = NNODE - 1; i >= 0; i--) if (nd_free[i]) n = i;
        if (n == NIL) return chs_pkg::ST_FULL;
        nd_free[n] = 1'b0;
        nd_val[n] = v;
        nd_next[n] = bkt_head[b];
        bkt_head[b] = n;
        return chs_pkg::ST_INSERTED;
      end
      chs_pkg::OP_DELETE: begin
        if (!find_node(b, v, hit, prv)) return chs_pkg::ST_NOT_FOUND;
        if (prv == NIL) bkt_head[b] = nd_next[hit];
        else nd_next[prv] = nd_next[hit];
        nd_next[hit] = NIL;
        nd_free[hit] = 1'b1;
        return chs_pkg::ST_DELETED;
      end
      default: return find_node(b, v, hit, prv) ? chs_pkg::ST_FOUND : chs_pkg::ST_NOT_FOUND;
    endcase
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [31:0] v, input bit chk,
                           input chs_pkg::status_e st);
    chs_pkg::status_e exp_st;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    exp_st = hash_set_apply(op, v);
    status_q.push_back(chk ? st : exp_st);
    if (op == chs_pkg::OP_INSERT && exp_st == chs_pkg::ST_INSERTED) live_vals.push_back(v);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= !(rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: expected none actual %0d", status_o);
      end else begin
        if (status_o !== status_q[0]) begin
          errors++;
          if (errors <= 10) $display("status mismatch: expected %0d actual %0d",
                                     status_q[0], status_o);
        end
        void'(status_q.pop_front());
      end
    end
  end

  task automatic drain;
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (status_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45 && live_vals.size() != 0) return live_vals[$urandom_range(live_vals.size() - 1)];
    if (r < 80) return $urandom_range(59);
    if (r < 90) return $urandom() & 32'h7fff_ffff;
    return $urandom();
  endfunction

  vec_t dir_tab[NDIR];

  initial begin
    int pct_tab[4][2] = '{'{0, 0}, '{50, 0}, '{0, 50}, '{18, 18}};
    logic [1:0] op;
    logic [31:0] v;
    int unsigned r;
    dir_tab = '{
      '{chs_pkg::OP_SEARCH, 32'd0, 1'b1, chs_pkg::ST_NOT_FOUND},
      '{chs_pkg::OP_DELETE, 32'd5, 1'b1, chs_pkg::ST_NOT_FOUND},
      '{chs_pkg::OP_INSERT, 32'd0, 1'b1, chs_pkg::ST_INSERTED},
      '{chs_pkg::OP_SEARCH, 32'd0, 1'b1, chs_pkg::ST_FOUND},
      '{chs_pkg::OP_INSERT, 32'h7fff_ffff, 1'b1, chs_pkg::ST_INSERTED},
      '{chs_pkg::OP_SEARCH, 32'h7fff_ffff, 1'b1, chs_pkg::ST_FOUND},
      '{chs_pkg::OP_INSERT, 32'h8000_0000, 1'b1, chs_pkg::ST_NEGATIVE},
      '{chs_pkg::OP_DELETE, 32'hffff_ffff, 1'b1, chs_pkg::ST_NEGATIVE},
      '{chs_pkg::OP_SEARCH, 32'h8000_0000, 1'b1, chs_pkg::ST_NEGATIVE},
      '{chs_pkg::OP_NONE, 32'd0, 1'b1, chs_pkg::ST_NOT_FOUND},
      '{chs_pkg::OP_NONE, 32'hffff_ffff, 1'b1, chs_pkg::ST_NOT_FOUND},
      '{chs_pkg::OP_INSERT, 32'd10, 1'b0, chs_pkg::ST_INSERTED},
      '{chs_pkg::OP_INSERT, 32'd20, 1'b0, chs_pkg::ST_INSERTED},
      '{chs_pkg::OP_INSERT, 32'd10, 1'b0, chs_pkg::ST_INSERTED},
      '{chs_pkg::OP_SEARCH, 32'd20, 1'b0, chs_pkg::ST_INSERTED},
      '{chs_pkg::OP_DELETE, 32'd10, 1'b0, chs_pkg::ST_INSERTED},
      '{chs_pkg::OP_DELETE, 32'd20, 1'b0, chs_pkg::ST_INSERTED},
      '{chs_pkg::OP_SEARCH, 32'd10, 1'b0, chs_pkg::ST_INSERTED},
      '{chs_pkg::OP_DELETE, 32'd0, 1'b0, chs_pkg::ST_INSERTED},
      '{chs_pkg::OP_DELETE, 32'd0, 1'b1, chs_pkg::ST_NOT_FOUND}
    };
    for (int i = 0; i < NBKT; i++) bkt_head[i] = NIL;
    for (int i = 0; i < NNODE; i++) begin
      nd_val[i] = '0;
      nd_next[i] = NIL;
      nd_free[i] = 1'b1;
    end
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir_tab[i]) send_beat(dir_tab[i].op, dir_tab[i].value, dir_tab[i].chk,
                                   dir_tab[i].st);
    // fill the pool past its end, then empty it again
    for (int i = 0; i < NNODE + 3; i++) send_beat(chs_pkg::OP_INSERT, $urandom_range(999),
                                                  1'b0, chs_pkg::ST_INSERTED);
    drain();
    while (live_vals.size() != 0) begin
      r = $urandom_range(live_vals.size() - 1);
      v = live_vals[r];
      live_vals.delete(r);
      send_beat(chs_pkg::OP_DELETE, v, 1'b0, chs_pkg::ST_INSERTED);
    end
    hold_cycles = 300;
    for (int i = 0; i < 8; i++) send_beat(chs_pkg::OP_SEARCH, $urandom_range(99), 1'b0,
                                          chs_pkg::ST_INSERTED);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct = pct_tab[ph][0];
      rx_stall_pct = pct_tab[ph][1];
      for (int i = 0; i < 320; i++) begin
        r = $urandom_range(99);
        op = (r < 40) ? chs_pkg::OP_INSERT : (r < 70) ? chs_pkg::OP_DELETE :
             (r < 97) ? chs_pkg::OP_SEARCH : chs_pkg::OP_NONE;
        v = pick_value();
        if (op == chs_pkg::OP_DELETE) begin
          for (int k = 0; k < live_vals.size(); k++) begin
            if (live_vals[k] == v) begin
              live_vals.delete(k);
              break;
            end
          end
        end
        send_beat(op, v, 1'b0, chs_pkg::ST_INSERTED);
      end
      drain();
    end
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    drain();
    repeat (200) @(negedge clk_i);
    if (errors == 0 && status_q.size() == 0) begin
      $display("tb_chained_hash_set_unit: PASS");
    end else begin
      $display("tb_chained_hash_set_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_chained_hash_set_unit: FAIL");
    $finish;
  end
endmodule
